// ===== rtl/prss_pkg.sv =====
// Shared types, codes and constants of the rotation sync and scan core.
package prss_pkg;

    localparam int unsigned SLICES_DEF       = 128;
    localparam int unsigned LEDS_PER_ARM_DEF = 64;
    localparam int unsigned GAMMA_DEPTH      = 256;

    localparam int unsigned DIV_NUM_W = 48;
    localparam int unsigned DIV_DEN_W = 32;

    localparam logic [DIV_NUM_W-1:0] RPM_NUMERATOR = 48'd60000000;

    localparam logic [15:0] ARM_B_OFFSET_RST = 16'd32768;
    localparam logic [19:0] MIN_EDGE_RST     = 20'd4000;
    localparam logic [15:0] MIN_RPM_RST      = 16'd200;

    typedef enum logic [2:0] {
        OP_HALL_EDGE   = 3'd0,
        OP_RENDER      = 3'd1,
        OP_WRITE_IMAGE = 3'd2,
        OP_WRITE_GAMMA = 3'd3,
        OP_IMAGE_DONE  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        REG_ARM_B_OFFSET = 2'd0,
        REG_MIN_EDGE     = 2'd1,
        REG_MIN_RPM      = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic        img_we;
        logic        gam_we;
        logic [14:0] addr;
        logic [7:0]  data;
    } t_mem_wr;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

// ===== rtl/prss_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module prss_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [prss_pkg::DIV_NUM_W-1:0]      i_dividend,
    input  logic [prss_pkg::DIV_DEN_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [prss_pkg::DIV_NUM_W-1:0]      o_quotient
);

    localparam int unsigned NW = prss_pkg::DIV_NUM_W;
    localparam int unsigned DW = prss_pkg::DIV_DEN_W;
    localparam int unsigned CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[NW-1]};
        diff  = trial - {1'b0, r_den};
        take  = (trial >= {1'b0, r_den});
        n_rem = take ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], take};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

// ===== rtl/prss_pixel_fetch.sv =====
// Image and gamma memories with the per-LED fetch sequence for both arms.
module prss_pixel_fetch #(
    parameter  int unsigned SLICES       = prss_pkg::SLICES_DEF,
    parameter  int unsigned LEDS_PER_ARM = prss_pkg::LEDS_PER_ARM_DEF,
    localparam int unsigned STORE_BYTES  = SLICES * LEDS_PER_ARM * 3,
    localparam int unsigned AW           = $clog2(STORE_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prss_pkg::t_mem_wr i_wr,
    input  logic              i_start,
    input  logic [AW-1:0]     i_addr_a,
    input  logic [AW-1:0]     i_addr_b,
    output logic              o_done,
    output prss_pkg::t_rgb    o_pix_a,
    output prss_pkg::t_rgb    o_pix_b
);

    localparam logic [1:0] LAST_CH = 2'd2;

    logic [7:0] r_image_mem [STORE_BYTES];
    logic [7:0] r_gamma_mem [prss_pkg::GAMMA_DEPTH];

    logic       r_busy;
    logic [1:0] r_ch;
    logic       r_s1_vld;
    logic [1:0] r_s1_ch;
    logic       r_s2_vld;
    logic [1:0] r_s2_ch;
    logic       r_done;

    logic [7:0] r_img_a;
    logic [7:0] r_img_b;
    logic [7:0] r_gam_a;
    logic [7:0] r_gam_b;
    logic [7:0] r_pix_a [3];
    logic [7:0] r_pix_b [3];

    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          img_in_range;

    assign rd_addr_a    = i_addr_a + AW'(r_ch);
    assign rd_addr_b    = i_addr_b + AW'(r_ch);
    assign img_in_range = (32'(i_wr.addr) < 32'(STORE_BYTES));

    // Image store: one write port, two read ports, registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr.img_we && img_in_range) begin
            r_image_mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        r_img_a <= r_image_mem[rd_addr_a];
        r_img_b <= r_image_mem[rd_addr_b];
    end

    // Gamma table is addressed directly by the image bytes just read.
    always_ff @(posedge i_clk) begin
        if (i_wr.gam_we && (i_wr.addr[14:8] == 7'd0)) begin
            r_gamma_mem[i_wr.addr[7:0]] <= i_wr.data;
        end
        r_gam_a <= r_gamma_mem[r_img_a];
        r_gam_b <= r_gamma_mem[r_img_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ch     <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_ch   <= '0;
            end else if (r_busy) begin
                r_ch <= r_ch + 1'b1;
                if (r_ch == LAST_CH) begin
                    r_busy <= 1'b0;
                end
            end
            r_s1_vld <= r_busy;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld && (r_s2_ch == LAST_CH);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ch <= r_ch;
        r_s2_ch <= r_s1_ch;
        if (r_s2_vld) begin
            r_pix_a[r_s2_ch] <= r_gam_a;
            r_pix_b[r_s2_ch] <= r_gam_b;
        end
    end

    assign o_done  = r_done;
    assign o_pix_a = '{red: r_pix_a[0], green: r_pix_a[1], blue: r_pix_a[2]};
    assign o_pix_b = '{red: r_pix_b[0], green: r_pix_b[1], blue: r_pix_b[2]};

endmodule

// ===== rtl/pov_rotation_sync_scanner_core.sv =====
// Top level: rotation timing, render sequencer, register port and output word register.
//
//  Channel | Direction | Handshake              | Contents
//  s_axis  | in        | tvalid/tready          | tuser opcode, tdata time/address/data
//  m_axis  | out       | tvalid/tready/tlast    | tuser is_pixel, tdata LED word
//  apb     | in        | psel/penable/pready    | three registers at 0x0, 0x4, 0x8, read as 32 bits
//
// Write, image-complete and ignored opcodes go from idle to the status word; a hall edge
// that passes its check first waits on the 48-step shared divider, which also forms the render phase.
// A render runs its setup (check, phase divide, slice, base address), then per LED
// three dual-port image reads, gamma lookup and capture, and handoff of the word.
// Reset is synchronous and clears the timing state; the memories are not cleared.
// A word is taken only when the core is idle; a stalled output pauses the LED walk.
module pov_rotation_sync_scanner_core #(
    parameter int unsigned SLICES       = prss_pkg::SLICES_DEF,
    parameter int unsigned LEDS_PER_ARM = prss_pkg::LEDS_PER_ARM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // time_us, address, write_data
    input  logic [2:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // led_index, arm_a_red, arm_a_green, arm_a_blue,
                                        // arm_b_red, arm_b_green, arm_b_blue, locked, speed_rpm
    output logic        m_axis_tuser,   // is_pixel
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned STORE_BYTES = SLICES * LEDS_PER_ARM * 3;
    localparam int unsigned AW          = $clog2(STORE_BYTES);
    localparam int unsigned SW          = $clog2(SLICES);
    localparam int unsigned PW          = 16 + SW;
    localparam logic [5:0]  LAST_LED    = 6'(LEDS_PER_ARM - 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ECHK   = 11'b000_0000_0010,
        S_EDIV   = 11'b000_0000_0100,
        S_STATUS = 11'b000_0000_1000,
        S_RCHK   = 11'b000_0001_0000,
        S_RDIV   = 11'b000_0010_0000,
        S_SLICE  = 11'b000_0100_0000,
        S_BASE   = 11'b000_1000_0000,
        S_FETCH  = 11'b001_0000_0000,
        S_WAIT   = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [15:0] r_cfg_offset;
    logic [19:0] r_cfg_min_edge;
    logic [15:0] r_cfg_min_rpm;

    logic [31:0] r_last_edge;
    logic [31:0] r_period;
    logic [25:0] r_rpm;
    logic        r_lock;
    logic        r_img_valid;

    logic [31:0]   r_time;
    logic          r_ok;
    logic [15:0]   r_pa;
    logic [SW-1:0] r_slice_a;
    logic [SW-1:0] r_slice_b;
    logic [AW-1:0] r_addr_a;
    logic [AW-1:0] r_addr_b;
    logic [5:0]    r_led;

    logic        r_out_valid;
    logic [87:0] r_out_data;
    logic        r_out_user;
    logic        r_out_last;

    logic                             in_acc;
    prss_pkg::t_opcode                in_op;
    prss_pkg::t_mem_wr                mem_wr;
    logic                             cfg_wr;
    logic                             out_free;
    logic [31:0]                      since_edge;
    logic [31:0]                      el_clamp;
    logic                             edge_ok;
    logic                             render_ok;
    logic                             div_start;
    logic [prss_pkg::DIV_NUM_W-1:0]   div_dividend;
    logic [prss_pkg::DIV_DEN_W-1:0]   div_divisor;
    logic                             div_done;
    logic [prss_pkg::DIV_NUM_W-1:0]   div_quot;
    logic [15:0]                      pb;
    logic [PW-1:0]                    prod_a;
    logic [PW-1:0]                    prod_b;
    logic                             fetch_start;
    logic                             fetch_done;
    prss_pkg::t_rgb                   pix_a;
    prss_pkg::t_rgb                   pix_b;
    prss_pkg::t_rgb                   col_a;
    prss_pkg::t_rgb                   col_b;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_op    = prss_pkg::t_opcode'(s_axis_tuser);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign mem_wr.img_we = in_acc && (in_op == prss_pkg::OP_WRITE_IMAGE);
    assign mem_wr.gam_we = in_acc && (in_op == prss_pkg::OP_WRITE_GAMMA);
    assign mem_wr.addr   = s_axis_tdata[46:32];
    assign mem_wr.data   = s_axis_tdata[54:47];

    // A timestamp before the last edge wraps to a large value and clamps to the period.
    assign since_edge = r_time - r_last_edge;
    assign el_clamp   = (since_edge > r_period) ? r_period : since_edge;
    assign edge_ok    = (since_edge > 32'(r_cfg_min_edge));
    assign render_ok  = r_lock && (r_rpm >= 26'(r_cfg_min_rpm)) && r_img_valid;

    assign div_start    = ((r_state == S_ECHK) && edge_ok) || ((r_state == S_RCHK) && render_ok);
    assign div_dividend = (r_state == S_ECHK) ? prss_pkg::RPM_NUMERATOR : {el_clamp, 16'd0};
    assign div_divisor  = since_edge & {32{r_state == S_ECHK}} | r_period & {32{r_state != S_ECHK}};

    assign pb     = r_pa + r_cfg_offset;
    assign prod_a = PW'(r_pa) * PW'(SLICES);
    assign prod_b = PW'(pb) * PW'(SLICES);

    assign fetch_start = (r_state == S_FETCH) && r_ok;
    assign col_a       = r_ok ? pix_a : '0;
    assign col_b       = r_ok ? pix_b : '0;

    prss_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    prss_pixel_fetch #(
        .SLICES       (SLICES),
        .LEDS_PER_ARM (LEDS_PER_ARM)
    ) u_fetch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (mem_wr),
        .i_start  (fetch_start),
        .i_addr_a (r_addr_a),
        .i_addr_b (r_addr_b),
        .o_done   (fetch_done),
        .o_pix_a  (pix_a),
        .o_pix_b  (pix_b)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        prss_pkg::OP_HALL_EDGE: n_state = S_ECHK;
                        prss_pkg::OP_RENDER:    n_state = S_RCHK;
                        default:                n_state = S_STATUS;
                    endcase
                end
            end
            S_ECHK:   n_state = edge_ok ? S_EDIV : S_STATUS;
            S_EDIV:   if (div_done) n_state = S_STATUS;
            S_STATUS: if (out_free) n_state = S_IDLE;
            S_RCHK:   n_state = render_ok ? S_RDIV : S_FETCH;
            S_RDIV:   if (div_done) n_state = S_SLICE;
            S_SLICE:  n_state = S_BASE;
            S_BASE:   n_state = S_FETCH;
            S_FETCH:  n_state = r_ok ? S_WAIT : S_EMIT;
            S_WAIT:   if (fetch_done) n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_led == LAST_LED) ? S_IDLE : S_FETCH;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_offset   <= prss_pkg::ARM_B_OFFSET_RST;
            r_cfg_min_edge <= prss_pkg::MIN_EDGE_RST;
            r_cfg_min_rpm  <= prss_pkg::MIN_RPM_RST;
            r_last_edge    <= '0;
            r_period       <= '0;
            r_rpm          <= '0;
            r_lock         <= 1'b0;
            r_img_valid    <= 1'b0;
            r_ok           <= 1'b0;
            r_led          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                unique case (prss_pkg::t_reg_idx'(paddr[3:2]))
                    prss_pkg::REG_ARM_B_OFFSET: r_cfg_offset   <= pwdata[15:0];
                    prss_pkg::REG_MIN_EDGE:     r_cfg_min_edge <= pwdata[19:0];
                    prss_pkg::REG_MIN_RPM:      r_cfg_min_rpm  <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_acc && (in_op == prss_pkg::OP_IMAGE_DONE)) begin
                r_img_valid <= 1'b1;
            end
            if ((r_state == S_EDIV) && div_done) begin
                r_period    <= since_edge;
                r_last_edge <= r_time;
                r_rpm       <= div_quot[25:0];
                r_lock      <= 1'b1;
            end
            if (r_state == S_RCHK) begin
                r_ok  <= render_ok;
                r_led <= '0;
            end else if ((r_state == S_EMIT) && out_free) begin
                r_led <= r_led + 1'b1;
            end
            if (((r_state == S_STATUS) || (r_state == S_EMIT)) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_time <= s_axis_tdata[31:0];
        end
        if ((r_state == S_RDIV) && div_done) begin
            // A phase of a full turn wraps to zero.
            r_pa <= div_quot[15:0];
        end
        if (r_state == S_SLICE) begin
            r_slice_a <= prod_a[PW-1:16];
            r_slice_b <= prod_b[PW-1:16];
        end
        if (r_state == S_BASE) begin
            r_addr_a <= AW'(r_slice_a) * AW'(LEDS_PER_ARM * 3);
            r_addr_b <= AW'(r_slice_b) * AW'(LEDS_PER_ARM * 3);
        end else if ((r_state == S_EMIT) && out_free) begin
            r_addr_a <= r_addr_a + AW'(3);
            r_addr_b <= r_addr_b + AW'(3);
        end
        if ((r_state == S_STATUS) && out_free) begin
            r_out_data <= {7'd0, r_rpm, r_lock, 48'd0, 6'd0};
            r_out_user <= 1'b0;
            r_out_last <= 1'b1;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_data <= {7'd0, r_rpm, r_lock,
                           col_b.blue, col_b.green, col_b.red,
                           col_a.blue, col_a.green, col_a.red, r_led};
            r_out_user <= 1'b1;
            r_out_last <= (r_led == LAST_LED);
        end
    end

    always_comb begin
        unique case (prss_pkg::t_reg_idx'(paddr[3:2]))
            prss_pkg::REG_ARM_B_OFFSET: prdata = 32'(r_cfg_offset);
            prss_pkg::REG_MIN_EDGE:     prdata = 32'(r_cfg_min_edge);
            prss_pkg::REG_MIN_RPM:      prdata = 32'(r_cfg_min_rpm);
            default:                    prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule
